// ----- design/sha1h_pkg.sv -----
package sha1h_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // block and schedule sizes
   localparam int BLOCK_BITS = 512;
   localparam int ROUNDS     = 80;
   localparam int WORDS      = 5;

   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [2:0] LAST_WORD  = 3'(WORDS - 1);

   // round constants
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // initial chaining words
   localparam logic [31:0] H_INIT [WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // source of the byte shifted into the block register
   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   typedef struct packed {
      logic       shift_en;
      logic [1:0] byte_sel;
      logic       count_inc;
      logic       load_len;
      logic       init_vars;
      logic       round_en;
      logic [6:0] round_idx;
      logic       add_chain;
      logic       restart;
      logic [2:0] word_idx;
   } cmd_type;

   typedef struct packed {
      logic fill_last;   // this shift completes the block
      logic fill_pad_end; // this shift leaves room for just the length
   } status_type;

endpackage

// ----- design/sha1h_datapath.sv -----
module sha1h_datapath (
   input  logic               clock,
   input  logic               reset,
   input  sha1h_pkg::cmd_type cmd,
   input  logic [7:0]         data_byte,
   output sha1h_pkg::status_type status,
   output logic [31:0]        digest_word
);
   import sha1h_pkg::*;

   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] var_ff [WORDS];
   logic [31:0] var_in [WORDS];
   logic [31:0] chain_ff [WORDS];
   logic [31:0] chain_in [WORDS];

   logic [7:0]  byte_val;
   logic [31:0] w0, w2, w8, w13, w_mix, w_new;
   logic [31:0] f_val, k_val, tmp;

   // byte source selection
   always_comb begin
      unique case (cmd.byte_sel)
         BSEL_DATA: byte_val = data_byte;
         BSEL_PAD:  byte_val = PAD_BYTE;
         BSEL_ZERO: byte_val = 8'h00;
         BSEL_LEN:  byte_val = len_ff[63:56];
         default:   byte_val = 8'h00;
      endcase
   end

   // schedule window taps, oldest word in the top bits
   assign w0    = blk_ff[511:480];
   assign w2    = blk_ff[447:416];
   assign w8    = blk_ff[255:224];
   assign w13   = blk_ff[95:64];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {w_mix[30:0], w_mix[31]};

   // round function and constant by round band
   always_comb begin
      if (cmd.round_idx < 7'd20) begin
         f_val = (var_ff[1] & var_ff[2]) | (~var_ff[1] & var_ff[3]);
         k_val = K0;
      end else if (cmd.round_idx < 7'd40) begin
         f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k_val = K1;
      end else if (cmd.round_idx < 7'd60) begin
         f_val = (var_ff[1] & var_ff[2]) | (var_ff[1] & var_ff[3])
               | (var_ff[2] & var_ff[3]);
         k_val = K2;
      end else begin
         f_val = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k_val = K3;
      end
   end

   assign tmp = {var_ff[0][26:0], var_ff[0][31:27]} + f_val + var_ff[4] + k_val + w0;

   // block register, fill pointer, count and length
   always_comb begin
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      len_in   = len_ff;
      if (cmd.shift_en) begin
         blk_in  = {blk_ff[BLOCK_BITS-9:0], byte_val};
         fill_in = fill_ff + 6'd1;
      end else if (cmd.round_en) begin
         blk_in = {blk_ff[BLOCK_BITS-33:0], w_new};
      end
      if (cmd.count_inc) count_in = count_ff + 64'd1;
      if (cmd.restart)   count_in = 64'd0;
      if (cmd.load_len) begin
         len_in = {count_ff[60:0], 3'b000};
      end else if (cmd.shift_en && cmd.byte_sel == BSEL_LEN) begin
         len_in = {len_ff[55:0], 8'h00};
      end
   end

   // working variables and chaining words
   always_comb begin
      for (int i = 0; i < WORDS; i++) begin
         var_in[i]   = var_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (cmd.init_vars) begin
         for (int i = 0; i < WORDS; i++) var_in[i] = chain_ff[i];
      end else if (cmd.round_en) begin
         var_in[0] = tmp;
         var_in[1] = var_ff[0];
         var_in[2] = {var_ff[1][1:0], var_ff[1][31:2]};
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3];
      end
      if (cmd.add_chain) begin
         for (int i = 0; i < WORDS; i++) chain_in[i] = chain_ff[i] + var_ff[i];
      end else if (cmd.restart) begin
         for (int i = 0; i < WORDS; i++) chain_in[i] = H_INIT[i];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      len_ff <= len_in;
      for (int i = 0; i < WORDS; i++) var_ff[i] <= var_in[i];
   end

   // state that reset brings to the start of a message
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 6'd0;
         count_ff <= 64'd0;
         for (int i = 0; i < WORDS; i++) chain_ff[i] <= H_INIT[i];
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         for (int i = 0; i < WORDS; i++) chain_ff[i] <= chain_in[i];
      end
   end

   assign status.fill_last    = (fill_ff == 6'd63);
   assign status.fill_pad_end = (fill_ff == 6'd55);
   assign digest_word         = chain_ff[cmd.word_idx];

endmodule

// ----- design/sha1h_ctrl.sv -----
module sha1h_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_kind,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tlast,
   input  sha1h_pkg::status_type status,
   output sha1h_pkg::cmd_type    cmd
);
   import sha1h_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ZERO  = 3'd2;
   localparam logic [2:0] S_LEN   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] ret_ff, ret_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      round_in   = round_ff;
      word_in    = word_ff;
      cmd        = '0;
      cmd.word_idx  = word_ff;
      cmd.round_idx = round_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == REQ_FINISH) begin
                  cmd.load_len = 1'b1;
                  state_in     = S_PAD;
               end else begin
                  cmd.shift_en  = 1'b1;
                  cmd.byte_sel  = BSEL_DATA;
                  cmd.count_inc = 1'b1;
                  if (status.fill_last) begin
                     cmd.init_vars = 1'b1;
                     state_in      = S_ROUND;
                     ret_in        = S_IDLE;
                     round_in      = 7'd0;
                  end
               end
            end
         end
         S_PAD: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_PAD;
            if (status.fill_last) begin
               cmd.init_vars = 1'b1;
               state_in      = S_ROUND;
               ret_in        = S_ZERO;
               round_in      = 7'd0;
            end else if (status.fill_pad_end) begin
               state_in = S_LEN;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_ZERO;
            if (status.fill_last) begin
               cmd.init_vars = 1'b1;
               state_in      = S_ROUND;
               ret_in        = S_ZERO;
               round_in      = 7'd0;
            end else if (status.fill_pad_end) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_LEN;
            if (status.fill_last) begin
               cmd.init_vars = 1'b1;
               state_in      = S_ROUND;
               ret_in        = S_EMIT;
               round_in      = 7'd0;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add_chain = 1'b1;
            word_in       = 3'd0;
            state_in      = ret_ff;
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (word_ff == LAST_WORD) begin
                  cmd.restart = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tlast = (word_ff == LAST_WORD);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         round_ff <= 7'd0;
         word_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

endmodule

// ----- design/sha1_message_hasher.sv -----
// a data request shifts one byte into the block; when it completes a 64-byte block
// it starts 80 rounds of the single shared round unit, followed by the chaining add
// a finish request pads byte-wise (0x80, zeros, then the 64-bit bit length), compressing
// one or two blocks, before the first digest word, then one word per accepted response
// requests are accepted only while idle, not during compression or digest output
// reset is synchronous, active high: initial chaining words, zero byte count, idle
module sha1_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] digest_word
   output logic [2:0]  rsp_tuser,  // [2:0] word_index
   output logic        rsp_tlast   // last_word
);
   import sha1h_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of load, padding, rounds and digest output
   sha1h_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   // block register, schedule, round unit and chaining words
   sha1h_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .status      (status),
      .digest_word (rsp_tdata)
   );

   assign rsp_tuser = cmd.word_idx;

endmodule
